>>> design/segment_segment_intersection_unit_macros.svh
// assertion macros for the segment intersection unit
// no dependencies; taken in by the files that carry assertions
`ifndef SEGMENT_SEGMENT_INTERSECTION_UNIT_MACROS_SVH
`define SEGMENT_SEGMENT_INTERSECTION_UNIT_MACROS_SVH

// condition in a cycle implies a consequence in the same cycle
`define SSI_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// condition in a cycle implies a consequence in the next cycle
`define SSI_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/ssi_pkg.sv
// types and widths shared by the segment intersection unit
// no dependencies
package ssi_pkg;

   localparam int COORD_BITS = 20;
   localparam int DIFF_W     = COORD_BITS + 1;
   localparam int PROD_W     = 2 * DIFF_W;
   localparam int SUM_W      = PROD_W + 1;
   localparam int NUM_W      = SUM_W + DIFF_W;
   localparam int QUO_W      = DIFF_W;
   localparam int VAL_W      = COORD_BITS + 2;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] seg1_start_x;
      logic signed [COORD_BITS-1:0] seg1_start_y;
      logic signed [COORD_BITS-1:0] seg1_end_x;
      logic signed [COORD_BITS-1:0] seg1_end_y;
      logic signed [COORD_BITS-1:0] seg2_start_x;
      logic signed [COORD_BITS-1:0] seg2_start_y;
      logic signed [COORD_BITS-1:0] seg2_end_x;
      logic signed [COORD_BITS-1:0] seg2_end_y;
   } req_type;

   typedef struct packed {
      logic                         hit;
      logic signed [COORD_BITS-1:0] cross_x;
      logic signed [COORD_BITS-1:0] cross_y;
   } rsp_type;

   // cross products and the pieces needed later
   typedef struct packed {
      logic signed [SUM_W-1:0]      den;
      logic signed [SUM_W-1:0]      sn;
      logic signed [SUM_W-1:0]      tn;
      logic signed [DIFF_W-1:0]     rx;
      logic signed [DIFF_W-1:0]     ry;
      logic signed [COORD_BITS-1:0] ax;
      logic signed [COORD_BITS-1:0] ay;
   } geom_type;

   // flags and base point carried alongside the divider
   typedef struct packed {
      logic                         hit;
      logic                         neg_x;
      logic                         neg_y;
      logic                         t_nz;
      logic                         rx_nz;
      logic                         ry_nz;
      logic signed [COORD_BITS-1:0] ax;
      logic signed [COORD_BITS-1:0] ay;
   } side_type;

endpackage

>>> design/ssi_front.sv
// front pipeline: differences, products and cross-product sums
// depends on ssi_pkg
module ssi_front
   import ssi_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     en,
   input  logic     in_valid,
   input  req_type  in_req,
   output logic     out_valid,
   output geom_type out_geom
);

   logic v1_ff, v2_ff, v3_ff;
   logic signed [DIFF_W-1:0] rx_ff, ry_ff, qx_ff, qy_ff, wx_ff, wy_ff;
   logic signed [DIFF_W-1:0] rx_in, ry_in, qx_in, qy_in, wx_in, wy_in;
   logic signed [COORD_BITS-1:0] ax1_ff, ay1_ff, ax2_ff, ay2_ff;
   logic signed [DIFF_W-1:0] rx2_ff, ry2_ff;
   logic signed [PROD_W-1:0] p0_ff, p1_ff, p2_ff, p3_ff, p4_ff, p5_ff;
   logic signed [PROD_W-1:0] p0_in, p1_in, p2_in, p3_in, p4_in, p5_in;
   geom_type geom_ff, geom_in;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // stage 1: direction and offset vectors
   always_comb begin
      rx_in = DIFF_W'(in_req.seg1_end_x) - DIFF_W'(in_req.seg1_start_x);
      ry_in = DIFF_W'(in_req.seg1_end_y) - DIFF_W'(in_req.seg1_start_y);
      qx_in = DIFF_W'(in_req.seg2_end_x) - DIFF_W'(in_req.seg2_start_x);
      qy_in = DIFF_W'(in_req.seg2_end_y) - DIFF_W'(in_req.seg2_start_y);
      wx_in = DIFF_W'(in_req.seg1_start_x) - DIFF_W'(in_req.seg2_start_x);
      wy_in = DIFF_W'(in_req.seg1_start_y) - DIFF_W'(in_req.seg2_start_y);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rx_ff  <= rx_in;
         ry_ff  <= ry_in;
         qx_ff  <= qx_in;
         qy_ff  <= qy_in;
         wx_ff  <= wx_in;
         wy_ff  <= wy_in;
         ax1_ff <= in_req.seg1_start_x;
         ay1_ff <= in_req.seg1_start_y;
      end
   end

   // stage 2: six products
   always_comb begin
      p0_in = PROD_W'(rx_ff) * PROD_W'(qy_ff);
      p1_in = PROD_W'(qx_ff) * PROD_W'(ry_ff);
      p2_in = PROD_W'(rx_ff) * PROD_W'(wy_ff);
      p3_in = PROD_W'(ry_ff) * PROD_W'(wx_ff);
      p4_in = PROD_W'(qx_ff) * PROD_W'(wy_ff);
      p5_in = PROD_W'(qy_ff) * PROD_W'(wx_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p0_ff  <= p0_in;
         p1_ff  <= p1_in;
         p2_ff  <= p2_in;
         p3_ff  <= p3_in;
         p4_ff  <= p4_in;
         p5_ff  <= p5_in;
         rx2_ff <= rx_ff;
         ry2_ff <= ry_ff;
         ax2_ff <= ax1_ff;
         ay2_ff <= ay1_ff;
      end
   end

   // stage 3: denominator and both numerators
   always_comb begin
      geom_in.den = SUM_W'(p0_ff) - SUM_W'(p1_ff);
      geom_in.sn  = SUM_W'(p2_ff) - SUM_W'(p3_ff);
      geom_in.tn  = SUM_W'(p4_ff) - SUM_W'(p5_ff);
      geom_in.rx  = rx2_ff;
      geom_in.ry  = ry2_ff;
      geom_in.ax  = ax2_ff;
      geom_in.ay  = ay2_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         geom_ff <= geom_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_geom  = geom_ff;

endmodule

>>> design/ssi_div.sv
// two-lane restoring divider, one quotient bit per stage, shared divisor
// depends on ssi_pkg and the assertion macro header
module ssi_div
   import ssi_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [NUM_W-1:0] in_num_x,
   input  logic [NUM_W-1:0] in_num_y,
   input  logic [SUM_W-1:0] in_den,
   input  side_type         in_side,
   output logic             out_valid,
   output logic [QUO_W-1:0] out_quo_x,
   output logic [QUO_W-1:0] out_quo_y,
   output logic             out_inexact_x,
   output logic             out_inexact_y,
   output side_type         out_side
);

`include "segment_segment_intersection_unit_macros.svh"

   logic             v_ff    [0:QUO_W];
   logic [SUM_W-1:0] rem_x_ff[0:QUO_W];
   logic [SUM_W-1:0] rem_y_ff[0:QUO_W];
   logic [QUO_W-1:0] low_x_ff[0:QUO_W];
   logic [QUO_W-1:0] low_y_ff[0:QUO_W];
   logic [QUO_W-1:0] quo_x_ff[0:QUO_W];
   logic [QUO_W-1:0] quo_y_ff[0:QUO_W];
   logic [SUM_W-1:0] den_ff  [0:QUO_W];
   side_type         side_ff [0:QUO_W];

   // load stage: for hits, the high part of the numerator is already below the divisor
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_x_ff[0] <= in_num_x[NUM_W-1:QUO_W];
         rem_y_ff[0] <= in_num_y[NUM_W-1:QUO_W];
         low_x_ff[0] <= in_num_x[QUO_W-1:0];
         low_y_ff[0] <= in_num_y[QUO_W-1:0];
         quo_x_ff[0] <= '0;
         quo_y_ff[0] <= '0;
         den_ff[0]   <= in_den;
         side_ff[0]  <= in_side;
      end
   end

   // one shift-compare-subtract per stage
   for (genvar g = 0; g < QUO_W; g++) begin : g_step
      logic [SUM_W:0]   try_x, try_y, dext;
      logic             ge_x, ge_y;
      logic [SUM_W-1:0] rem_x_in, rem_y_in;

      always_comb begin
         dext     = {1'b0, den_ff[g]};
         try_x    = {rem_x_ff[g], low_x_ff[g][QUO_W-1]};
         try_y    = {rem_y_ff[g], low_y_ff[g][QUO_W-1]};
         ge_x     = (try_x >= dext);
         ge_y     = (try_y >= dext);
         rem_x_in = ge_x ? SUM_W'(try_x - dext) : SUM_W'(try_x);
         rem_y_in = ge_y ? SUM_W'(try_y - dext) : SUM_W'(try_y);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[g+1] <= 1'b0;
         end else if (en) begin
            v_ff[g+1] <= v_ff[g];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_x_ff[g+1] <= rem_x_in;
            rem_y_ff[g+1] <= rem_y_in;
            low_x_ff[g+1] <= {low_x_ff[g][QUO_W-2:0], 1'b0};
            low_y_ff[g+1] <= {low_y_ff[g][QUO_W-2:0], 1'b0};
            quo_x_ff[g+1] <= {quo_x_ff[g][QUO_W-2:0], ge_x};
            quo_y_ff[g+1] <= {quo_y_ff[g][QUO_W-2:0], ge_y};
            den_ff[g+1]   <= den_ff[g];
            side_ff[g+1]  <= side_ff[g];
         end
      end
   end

   assign out_valid     = v_ff[QUO_W];
   assign out_quo_x     = quo_x_ff[QUO_W];
   assign out_quo_y     = quo_y_ff[QUO_W];
   assign out_inexact_x = (rem_x_ff[QUO_W] != '0);
   assign out_inexact_y = (rem_y_ff[QUO_W] != '0);
   assign out_side      = side_ff[QUO_W];

   // remainders stay below a nonzero divisor for hits
   `SSI_ASSERT_IMP(a_rem_x_lt_den, clock, reset, v_ff[QUO_W] && side_ff[QUO_W].hit, rem_x_ff[QUO_W] < den_ff[QUO_W], "x remainder not below divisor")
   `SSI_ASSERT_IMP(a_rem_y_lt_den, clock, reset, v_ff[QUO_W] && side_ff[QUO_W].hit, rem_y_ff[QUO_W] < den_ff[QUO_W], "y remainder not below divisor")

endmodule

>>> design/segment_segment_intersection_unit.sv
// channel   | dir | handshake               | payload
// request   | in  | req_valid / req_stall   | req_data  (two segments)
// response  | out | rsp_valid / rsp_stall   | rsp_data  (hit, cross point)
//
// one request per cycle unless a held response stalls the pipeline; stages: 3 front, 1 test, 1 scale,
// 1 divider load, 21 divider bits (the bit-serial divider stages), 1 output
// the whole pipeline advances together; a stalled response freezes every stage
// reset is synchronous, active high, and clears only valid bits
// depends on ssi_pkg, ssi_front, ssi_div and the assertion macro header
module segment_segment_intersection_unit
   import ssi_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_stall,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

`include "segment_segment_intersection_unit_macros.svh"

   logic     en;
   logic     front_valid;
   geom_type front_geom;

   logic               t_valid_ff;
   side_type           t_side_ff, t_side_in;
   logic [SUM_W-1:0]   t_tmag_ff, t_dmag_ff, t_tmag_in, t_dmag_in;
   logic [DIFF_W-1:0]  t_rxmag_ff, t_rymag_ff, t_rxmag_in, t_rymag_in;

   logic               m_valid_ff;
   side_type           m_side_ff;
   logic [SUM_W-1:0]   m_dmag_ff;
   logic [NUM_W-1:0]   m_num_x_ff, m_num_y_ff, m_num_x_in, m_num_y_in;

   logic               d_valid;
   logic [QUO_W-1:0]   d_quo_x, d_quo_y;
   logic               d_inexact_x, d_inexact_y;
   side_type           d_side;

   logic               rsp_valid_ff;
   rsp_type            rsp_ff, rsp_in;
   logic signed [VAL_W-1:0] val_x, val_y;

   // global advance while the output slot is free or being taken
   assign en        = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;

   ssi_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_req    (req_data),
      .out_valid (front_valid),
      .out_geom  (front_geom)
   );

   // range test with sign-adjusted comparisons, magnitudes and signs
   always_comb begin
      logic den_pos, s_ok, t_ok;
      den_pos = (front_geom.den > 0);
      if (den_pos) begin
         s_ok = (front_geom.sn >= 0) && (front_geom.sn <= front_geom.den);
         t_ok = (front_geom.tn >= 0) && (front_geom.tn <= front_geom.den);
      end else begin
         s_ok = (front_geom.sn <= 0) && (front_geom.sn >= front_geom.den);
         t_ok = (front_geom.tn <= 0) && (front_geom.tn >= front_geom.den);
      end
      t_side_in.hit   = (front_geom.den != 0) && s_ok && t_ok;
      t_side_in.neg_x = (front_geom.tn < 0) ^ (front_geom.rx < 0) ^ (front_geom.den < 0);
      t_side_in.neg_y = (front_geom.tn < 0) ^ (front_geom.ry < 0) ^ (front_geom.den < 0);
      t_side_in.t_nz  = (front_geom.tn != 0);
      t_side_in.rx_nz = (front_geom.rx != 0);
      t_side_in.ry_nz = (front_geom.ry != 0);
      t_side_in.ax    = front_geom.ax;
      t_side_in.ay    = front_geom.ay;
      t_tmag_in  = front_geom.tn[SUM_W-1] ? SUM_W'(-front_geom.tn) : SUM_W'(front_geom.tn);
      t_dmag_in  = front_geom.den[SUM_W-1] ? SUM_W'(-front_geom.den) : SUM_W'(front_geom.den);
      t_rxmag_in = front_geom.rx[DIFF_W-1] ? DIFF_W'(-front_geom.rx) : DIFF_W'(front_geom.rx);
      t_rymag_in = front_geom.ry[DIFF_W-1] ? DIFF_W'(-front_geom.ry) : DIFF_W'(front_geom.ry);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t_valid_ff <= 1'b0;
         m_valid_ff <= 1'b0;
      end else if (en) begin
         t_valid_ff <= front_valid;
         m_valid_ff <= t_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t_side_ff  <= t_side_in;
         t_tmag_ff  <= t_tmag_in;
         t_dmag_ff  <= t_dmag_in;
         t_rxmag_ff <= t_rxmag_in;
         t_rymag_ff <= t_rymag_in;
      end
   end

   // scale the t numerator by each direction component
   always_comb begin
      m_num_x_in = NUM_W'(t_tmag_ff) * NUM_W'(t_rxmag_ff);
      m_num_y_in = NUM_W'(t_tmag_ff) * NUM_W'(t_rymag_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_side_ff  <= t_side_ff;
         m_dmag_ff  <= t_dmag_ff;
         m_num_x_ff <= m_num_x_in;
         m_num_y_ff <= m_num_y_in;
      end
   end

   ssi_div u_div (
      .clock         (clock),
      .reset         (reset),
      .en            (en),
      .in_valid      (m_valid_ff),
      .in_num_x      (m_num_x_ff),
      .in_num_y      (m_num_y_ff),
      .in_den        (m_dmag_ff),
      .in_side       (m_side_ff),
      .out_valid     (d_valid),
      .out_quo_x     (d_quo_x),
      .out_quo_y     (d_quo_y),
      .out_inexact_x (d_inexact_x),
      .out_inexact_y (d_inexact_y),
      .out_side      (d_side)
   );

   // add offset to base point and truncate toward zero
   always_comb begin
      logic signed [VAL_W-1:0] off_x, off_y;
      off_x = d_side.neg_x ? -$signed(VAL_W'(d_quo_x)) : $signed(VAL_W'(d_quo_x));
      off_y = d_side.neg_y ? -$signed(VAL_W'(d_quo_y)) : $signed(VAL_W'(d_quo_y));
      val_x = VAL_W'(d_side.ax) + off_x;
      val_y = VAL_W'(d_side.ay) + off_y;
      if (d_inexact_x && d_side.t_nz && d_side.rx_nz) begin
         if (d_side.neg_x && val_x > 0) begin
            val_x = val_x - VAL_W'(1);
         end else if (!d_side.neg_x && val_x < 0) begin
            val_x = val_x + VAL_W'(1);
         end
      end
      if (d_inexact_y && d_side.t_nz && d_side.ry_nz) begin
         if (d_side.neg_y && val_y > 0) begin
            val_y = val_y - VAL_W'(1);
         end else if (!d_side.neg_y && val_y < 0) begin
            val_y = val_y + VAL_W'(1);
         end
      end
      rsp_in.hit     = d_side.hit;
      rsp_in.cross_x = d_side.hit ? val_x[COORD_BITS-1:0] : '0;
      rsp_in.cross_y = d_side.hit ? val_y[COORD_BITS-1:0] : '0;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= d_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `SSI_ASSERT_IMP(a_miss_zero, clock, reset, rsp_valid && !rsp_data.hit, rsp_data.cross_x == '0 && rsp_data.cross_y == '0, "miss with nonzero point")
   `SSI_ASSERT_NXT(a_stall_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "response lost under stall")
   `SSI_ASSERT_IMP(a_hit_den, clock, reset, t_valid_ff && t_side_ff.hit, t_dmag_ff != '0, "hit with zero denominator")

endmodule
